>>> rtl/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
// Used by mlr_setup, mlr_step and midpoint_line_rasterizer; depends on nothing.
`default_nettype none

package mlr_pkg;

    // Field widths.
    localparam int COORD_BITS = 10;
    localparam int VALUE_BITS = 8;
    // Running line value: along the walk |L| stays below about 3 * 2^COORD_BITS.
    localparam int LVAL_BITS  = COORD_BITS + 4;

    // Operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Slope classes.
    localparam logic [1:0] CLASS_SHALLOW_UP   = 2'd0;  // 0 <= m <= 1
    localparam logic [1:0] CLASS_STEEP_UP     = 2'd1;  // m > 1
    localparam logic [1:0] CLASS_SHALLOW_DOWN = 2'd2;  // -1 <= m < 0
    localparam logic [1:0] CLASS_STEEP_DOWN   = 2'd3;  // m < -1

    typedef logic [COORD_BITS-1:0]        coord_t;
    typedef logic [VALUE_BITS-1:0]        value_t;
    typedef logic signed [COORD_BITS:0]   coef_t;
    typedef logic signed [LVAL_BITS-1:0]  lval_t;

    // One input item.
    typedef struct packed {
        logic   op;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        value_t line_value;
    } in_item_t;

    // One result item.
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        value_t pixel_value;
        logic   last_pixel;
    } out_item_t;

    // Line description worked out on a load.
    typedef struct packed {
        coord_t     walk_x;
        coord_t     walk_y;
        coord_t     major_end;
        logic [1:0] slope_class;
        coef_t      coef_a;
        coef_t      coef_b;
    } line_setup_t;

    // Outcome of one step of the walk.
    typedef struct packed {
        coord_t next_x;
        coord_t next_y;
        lval_t  next_lval;
        logic   last;
    } step_t;

endpackage : mlr_pkg

`default_nettype wire

>>> rtl/mlr_setup.sv
// Load decoder: line coefficients, slope class and endpoint ordering.
// Depends on mlr_pkg.
`default_nettype none

module mlr_setup (
    input  wire mlr_pkg::in_item_t item,
    output mlr_pkg::line_setup_t   setup
);
    import mlr_pkg::*;

    typedef logic signed [COORD_BITS+1:0] delta_t;

    delta_t dx_raw;
    delta_t dy_raw;
    delta_t dx_abs;
    delta_t dy_adj;
    logic [1:0] cls;
    logic x_major;
    logic swap;

    // Deltas, with the direction flipped so that dx is never negative.
    always_comb
    begin
        dx_raw = delta_t'({2'b00, item.end_x}) - delta_t'({2'b00, item.start_x});
        dy_raw = delta_t'({2'b00, item.end_y}) - delta_t'({2'b00, item.start_y});
        if (dx_raw < 0)
        begin
            dx_abs = -dx_raw;
            dy_adj = -dy_raw;
        end
        else
        begin
            dx_abs = dx_raw;
            dy_adj = dy_raw;
        end
    end

    // Slope class from comparing the deltas, with no division.
    always_comb
    begin
        if (dy_adj >= 0 && dy_adj <= dx_abs)
            cls = CLASS_SHALLOW_UP;
        else if (dy_adj > dx_abs)
            cls = CLASS_STEEP_UP;
        else if (dy_adj >= -dx_abs)
            cls = CLASS_SHALLOW_DOWN;
        else
            cls = CLASS_STEEP_DOWN;
    end

    // Order the endpoints so that the walk climbs the major axis.
    assign x_major = (cls == CLASS_SHALLOW_UP) || (cls == CLASS_SHALLOW_DOWN);
    assign swap    = x_major ? (item.start_x > item.end_x) : (item.start_y > item.end_y);

    always_comb
    begin
        setup.slope_class = cls;
        setup.coef_a = coef_t'({1'b0, item.start_y}) - coef_t'({1'b0, item.end_y});
        setup.coef_b = coef_t'({1'b0, item.end_x}) - coef_t'({1'b0, item.start_x});
        setup.walk_x = swap ? item.end_x : item.start_x;
        setup.walk_y = swap ? item.end_y : item.start_y;
        if (x_major)
            setup.major_end = swap ? item.start_x : item.end_x;
        else
            setup.major_end = swap ? item.start_y : item.end_y;
    end

endmodule : mlr_setup

`default_nettype wire

>>> rtl/mlr_step.sv
// One midpoint step: last-pixel test and choice between the straight and
// diagonal neighbour, using the running line value. Depends on mlr_pkg.
`default_nettype none

module mlr_step (
    input  wire mlr_pkg::coord_t walk_x,
    input  wire mlr_pkg::coord_t walk_y,
    input  wire mlr_pkg::coord_t major_end,
    input  wire logic [1:0]      slope_class,
    input  wire mlr_pkg::coef_t  coef_a,
    input  wire mlr_pkg::coef_t  coef_b,
    input  wire mlr_pkg::lval_t  lval,
    output mlr_pkg::step_t       step
);
    import mlr_pkg::*;

    logic  x_major;
    lval_t a_ext;
    lval_t b_ext;
    lval_t major_delta;
    lval_t minor_delta;
    lval_t l_straight;
    lval_t l_diag;
    lval_t mag_straight;
    lval_t mag_diag;
    logic  take_diag;
    coord_t minor_inc;

    assign x_major = (slope_class == CLASS_SHALLOW_UP) || (slope_class == CLASS_SHALLOW_DOWN);
    assign a_ext   = lval_t'(coef_a);
    assign b_ext   = lval_t'(coef_b);

    // Change in L for a move along the major axis and for the minor move.
    always_comb
    begin
        case (slope_class)
            CLASS_SHALLOW_UP:
            begin
                major_delta = a_ext;
                minor_delta = b_ext;
            end
            CLASS_STEEP_UP:
            begin
                major_delta = b_ext;
                minor_delta = a_ext;
            end
            CLASS_SHALLOW_DOWN:
            begin
                major_delta = a_ext;
                minor_delta = -b_ext;
            end
            default:
            begin
                major_delta = b_ext;
                minor_delta = -a_ext;
            end
        endcase
    end

    // Line value at both candidates and the comparison of magnitudes.
    assign l_straight   = lval + major_delta;
    assign l_diag       = l_straight + minor_delta;
    assign mag_straight = (l_straight < 0) ? -l_straight : l_straight;
    assign mag_diag     = (l_diag < 0) ? -l_diag : l_diag;
    assign take_diag    = $unsigned(mag_straight) > $unsigned(mag_diag);
    assign minor_inc    = take_diag ? coord_t'(1) : coord_t'(0);

    // Next pixel position; the minor coordinate wraps within its width.
    always_comb
    begin
        step.last      = x_major ? (walk_x == major_end) : (walk_y == major_end);
        step.next_lval = take_diag ? l_diag : l_straight;
        case (slope_class)
            CLASS_SHALLOW_UP:
            begin
                step.next_x = walk_x + coord_t'(1);
                step.next_y = walk_y + minor_inc;
            end
            CLASS_STEEP_UP:
            begin
                step.next_x = walk_x + minor_inc;
                step.next_y = walk_y + coord_t'(1);
            end
            CLASS_SHALLOW_DOWN:
            begin
                step.next_x = walk_x + coord_t'(1);
                step.next_y = walk_y - minor_inc;
            end
            default:
            begin
                step.next_x = walk_x - minor_inc;
                step.next_y = walk_y + coord_t'(1);
            end
        endcase
    end

endmodule : mlr_step

`default_nettype wire

>>> rtl/midpoint_line_rasterizer.sv
// Midpoint line rasterizer top level: input register, line state and pixel register.
// Depends on mlr_pkg, mlr_setup and mlr_step.
//
//   Channel | Valid       | Stall       | Payload           | Moves
//   --------+-------------+-------------+-------------------+------------------------
//   input   | item_valid  | item_stall  | item (in_item_t)  | load or step commands
//   output  | pixel_valid | pixel_stall | pixel (out_item_t)| at most one pixel per step
//
// One item per clock is taken while no pixel is stalled; a step is held in the
// input register and its pixel in the pixel register. The line value is tracked
// incrementally, so each step is two adds and a magnitude compare between the
// input register and the pixel register.
// Reset clears the line state, so a step before any load gives no pixel.
// A stalled pixel holds the input register, and whatever item sits in it, until
// the pixel is taken; item_stall is raised for as long as that lasts.
`default_nettype none

module midpoint_line_rasterizer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire mlr_pkg::in_item_t   item,
    output logic                     pixel_valid,
    input  wire logic                pixel_stall,
    output mlr_pkg::out_item_t       pixel
);
    import mlr_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_data_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    coord_t      walk_x_reg;
    coord_t      walk_y_reg;
    coord_t      major_end_reg;
    logic [1:0]  slope_class_reg;
    coef_t       coef_a_reg;
    coef_t       coef_b_reg;
    lval_t       lval_reg;
    value_t      held_value_reg;
    logic        line_active_reg;

    logic        advance;
    logic        is_load;
    logic        emit;
    line_setup_t setup;
    step_t       step;

    mlr_setup u_setup (
        .item  (in_data_reg),
        .setup (setup)
    );

    mlr_step u_step (
        .walk_x      (walk_x_reg),
        .walk_y      (walk_y_reg),
        .major_end   (major_end_reg),
        .slope_class (slope_class_reg),
        .coef_a      (coef_a_reg),
        .coef_b      (coef_b_reg),
        .lval        (lval_reg),
        .step        (step)
    );

    // The held item goes ahead whenever the pixel register can take a result.
    assign advance    = in_valid_reg && (!out_valid_reg || !pixel_stall);
    assign is_load    = (in_data_reg.op == OP_LOAD);
    assign emit       = advance && !is_load && line_active_reg;
    assign item_stall = in_valid_reg && !advance;

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_data_reg;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_valid && !item_stall)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_data_reg <= item;
    end

    // Line state: replaced on a load, walked on a step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_x_reg      <= '0;
            walk_y_reg      <= '0;
            major_end_reg   <= '0;
            slope_class_reg <= CLASS_SHALLOW_UP;
            coef_a_reg      <= '0;
            coef_b_reg      <= '0;
            lval_reg        <= '0;
            held_value_reg  <= '0;
            line_active_reg <= 1'b0;
        end
        else if (advance && is_load)
        begin
            walk_x_reg      <= setup.walk_x;
            walk_y_reg      <= setup.walk_y;
            major_end_reg   <= setup.major_end;
            slope_class_reg <= setup.slope_class;
            coef_a_reg      <= setup.coef_a;
            coef_b_reg      <= setup.coef_b;
            // The line passes through the walk's starting endpoint, so L starts at zero.
            lval_reg        <= '0;
            held_value_reg  <= in_data_reg.line_value;
            line_active_reg <= 1'b1;
        end
        else if (emit)
        begin
            if (step.last)
                line_active_reg <= 1'b0;
            else
            begin
                walk_x_reg <= step.next_x;
                walk_y_reg <= step.next_y;
                lval_reg   <= step.next_lval;
            end
        end
    end

    // Pixel register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (!pixel_stall)
            out_valid_reg <= 1'b0;
    end

    // Pixel register payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.pixel_x     <= walk_x_reg;
            out_data_reg.pixel_y     <= walk_y_reg;
            out_data_reg.pixel_value <= held_value_reg;
            out_data_reg.last_pixel  <= step.last;
        end
    end

endmodule : midpoint_line_rasterizer

`default_nettype wire
